// ----- rtl/lifeg_pkg.sv -----
// lifeg_pkg: grid size, action codes, cell commands and controller states
// shared by the life automaton grid modules; depends on nothing

package lifeg_pkg;

  localparam int ROWS = 32;
  localparam int COLS = 64;

  // a readout never emits more rows than the 5-bit row index can name
  localparam int RD_ROWS = (ROWS < 32) ? ROWS : 32;

  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = $clog2(COLS);
  localparam int CNT_W = $clog2(ROWS);

  localparam int ACT_W   = 2;
  localparam int IN_ROW_W = 5;
  localparam int IN_COL_W = 6;
  localparam int GEN_W   = 16;
  localparam int OUT_IDX_W = 5;
  localparam int OUT_ROW_W = 64;

  typedef enum logic [ACT_W-1:0] {
    ACT_SET  = 2'd0,
    ACT_STEP = 2'd1,
    ACT_READ = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_SET,
    OP_STEP,
    OP_ROT
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_READ
  } ctrl_state_t;

endpackage

// ----- rtl/lifeg_cell.sv -----
// lifeg_cell: one grid row; holds its cells, applies B3/S23 against its
// neighbor rows, sets a cell or takes the next row in a rotation; uses lifeg_pkg

module lifeg_cell
  import lifeg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [ROW_W-1:0] cell_idx,
  input  cell_cmd_t        cmd,
  input  logic [COLS-1:0]  up_row,
  input  logic [COLS-1:0]  dn_row,
  input  logic [COLS-1:0]  rot_row,
  output logic [COLS-1:0]  row_q,
  output logic             changed
);

  logic [COLS-1:0] row_r;
  logic [COLS-1:0] row_nxt;
  logic [COLS-1:0] gen_row;

  // bit-sliced neighbor count mod 8 over the eight neighbor planes
  always_comb begin
    logic [COLS-1:0] plane [8];
    logic [COLS-1:0] s0;
    logic [COLS-1:0] s1;
    logic [COLS-1:0] s2;
    logic [COLS-1:0] c0;
    logic [COLS-1:0] c1;
    plane[0] = up_row << 1;
    plane[1] = up_row;
    plane[2] = up_row >> 1;
    plane[3] = row_r << 1;
    plane[4] = row_r >> 1;
    plane[5] = dn_row << 1;
    plane[6] = dn_row;
    plane[7] = dn_row >> 1;
    s0 = '0;
    s1 = '0;
    s2 = '0;
    for (int p = 0; p < 8; p++) begin
      c0 = s0 & plane[p];
      s0 = s0 ^ plane[p];
      c1 = s1 & c0;
      s1 = s1 ^ c0;
      s2 = s2 ^ c1;
    end
    // three -> alive, two -> keep
    gen_row = s1 & ~s2 & (s0 | row_r);
  end

  always_comb begin
    row_nxt = row_r;
    case (cmd.op)
      OP_SET: begin
        if (cmd.row == cell_idx) begin
          row_nxt[cmd.col] = 1'b1;
        end
      end
      OP_STEP: row_nxt = gen_row;
      OP_ROT:  row_nxt = rot_row;
      default: row_nxt = row_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else begin
      row_r <= row_nxt;
    end
  end

  assign row_q   = row_r;
  assign changed = (gen_row != row_r);

endmodule

// ----- rtl/lifeg_ctrl.sv -----
// lifeg_ctrl: sequencer for set, advance and readout; drives the command
// shared by all row cells and the readout handshake; uses lifeg_pkg

module lifeg_ctrl
  import lifeg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ACT_W-1:0]     in_action,
  input  logic [IN_ROW_W-1:0]  in_row,
  input  logic [IN_COL_W-1:0]  in_col,
  input  logic [GEN_W-1:0]     in_count,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_IDX_W-1:0] out_row_index,
  output logic                 out_last,
  input  logic                 any_changed,
  output cell_cmd_t            cmd
);

  ctrl_state_t      state_r;
  ctrl_state_t      state_nxt;
  logic [GEN_W-1:0] gen_r;
  logic [GEN_W-1:0] gen_nxt;
  logic [CNT_W-1:0] rd_r;
  logic [CNT_W-1:0] rd_nxt;
  logic             in_xfer;
  logic             rd_adv;
  logic             on_grid;

  assign in_xfer = in_valid && in_ready;
  assign on_grid = (32'(in_row) < 32'(ROWS)) && (32'(in_col) < 32'(COLS));

  // rows past the readout window still rotate so the grid returns home
  assign rd_adv = (state_r == ST_READ) && (out_ready || !out_valid);

  always_comb begin
    state_nxt = state_r;
    gen_nxt   = gen_r;
    rd_nxt    = rd_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          case (action_t'(in_action))
            ACT_STEP: begin
              if (in_count != '0) begin
                state_nxt = ST_RUN;
                gen_nxt   = in_count;
              end
            end
            ACT_READ: begin
              state_nxt = ST_READ;
              rd_nxt    = '0;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RUN: begin
        gen_nxt = gen_r - GEN_W'(1);
        // a still life stops the run early
        if (gen_r == GEN_W'(1) || !any_changed) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        if (rd_adv) begin
          rd_nxt = rd_r + CNT_W'(1);
          if (rd_r == CNT_W'(ROWS - 1)) begin
            state_nxt = ST_IDLE;
            rd_nxt    = '0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    out_valid     = (state_r == ST_READ) && (32'(rd_r) < 32'(RD_ROWS));
    out_row_index = OUT_IDX_W'(rd_r);
    out_last      = (32'(rd_r) == 32'(RD_ROWS - 1));
    cmd.op        = OP_HOLD;
    cmd.row       = ROW_W'(in_row);
    cmd.col       = COL_W'(in_col);
    case (state_r)
      ST_IDLE: begin
        if (in_xfer && action_t'(in_action) == ACT_SET && on_grid) begin
          cmd.op = OP_SET;
        end
      end
      ST_RUN:  cmd.op = OP_STEP;
      ST_READ: begin
        if (rd_adv) begin
          cmd.op = OP_ROT;
        end
      end
      default: cmd.op = OP_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      gen_r   <= '0;
      rd_r    <= '0;
    end else begin
      state_r <= state_nxt;
      gen_r   <= gen_nxt;
      rd_r    <= rd_nxt;
    end
  end

endmodule

// ----- rtl/life_automaton_grid.sv -----
// life_automaton_grid: Game of Life B3/S23 grid as a column of row cells
// under one sequencer; uses lifeg_pkg, lifeg_cell and lifeg_ctrl
//
//   channel  ports                                     carries
//   in       in_valid in_ready in_action/row/col/count one action
//   out      out_valid out_ready out_row_index/...     one grid row
//
// set cell and action 3: the next transfer is taken right after
// advance: one generation per cycle (all rows update together), ends early
//   on a still life; count 0 advances nothing and the block stays idle
// readout: the rows rotate through row 0 one per out transfer; out_ready
//   low holds the rotation
// reset clears every cell at once; no input is taken during advance or readout

module life_automaton_grid
  import lifeg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ACT_W-1:0]     in_action,
  input  logic [IN_ROW_W-1:0]  in_row,
  input  logic [IN_COL_W-1:0]  in_col,
  input  logic [GEN_W-1:0]     in_count,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_IDX_W-1:0] out_row_index,
  output logic [OUT_ROW_W-1:0] out_row_cells,
  output logic                 out_last
);

  cell_cmd_t       cmd;
  logic [COLS-1:0] grid_w [ROWS];
  logic [ROWS-1:0] changed_w;
  logic            any_changed;

  assign any_changed = |changed_w;

  lifeg_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_row        (in_row),
    .in_col        (in_col),
    .in_count      (in_count),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_row_index (out_row_index),
    .out_last      (out_last),
    .any_changed   (any_changed),
    .cmd           (cmd)
  );

  for (genvar k = 0; k < ROWS; k++) begin : g_cell
    logic [COLS-1:0] up_w;
    logic [COLS-1:0] dn_w;
    logic [COLS-1:0] rot_w;

    // dead border above the first and below the last row
    if (k == 0) begin : g_top
      assign up_w = '0;
    end else begin : g_mid_up
      assign up_w = grid_w[k-1];
    end

    if (k == ROWS - 1) begin : g_bot
      assign dn_w  = '0;
      assign rot_w = grid_w[0];
    end else begin : g_mid_dn
      assign dn_w  = grid_w[k+1];
      assign rot_w = grid_w[k+1];
    end

    lifeg_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (ROW_W'(k)),
      .cmd      (cmd),
      .up_row   (up_w),
      .dn_row   (dn_w),
      .rot_row  (rot_w),
      .row_q    (grid_w[k]),
      .changed  (changed_w[k])
    );
  end

  assign out_row_cells = OUT_ROW_W'(grid_w[0]);

  // readout starts at row zero right after the read transfer
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_action == ACT_READ) |=>
      (out_valid && out_row_index == '0))
    else $error("readout did not start at row zero");

  // rows come out in order, one per transfer
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=>
      (out_valid && out_row_index == OUT_IDX_W'($past(out_row_index) + 1'b1)))
    else $error("readout row sequence broken");

  // no input while a readout is under way
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken during readout");

  // after the last row the block is free again when every row was emitted
  assert property (@(posedge clk) disable iff (!rst_n)
    (ROWS <= 32 && out_valid && out_ready && out_last) |=> in_ready)
    else $error("block stuck after readout");

endmodule
